>>> src/jkx_pkg.sv
package jkx_pkg;

    localparam int KEY_MAX   = 16;
    localparam int LEN_W     = $clog2(KEY_MAX + 1);
    localparam int KIDX_W    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KEY_BITS  = 128;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

    // characters
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_COLON  = 3'd1,
        PH_SPACE  = 3'd2,
        PH_VALUE  = 3'd3,
        PH_ESCAPE = 3'd4,
        PH_DONE   = 3'd5
    } jkx_phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_FAIL = 2'd2
    } jkx_kind_t;

    // work for the back end: an optional first result and an optional trailing failure
    typedef struct packed {
        logic [7:0] data;
        jkx_kind_t  kind;
        logic       emit;
        logic       tail_fail;
    } jkx_cmd_t;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_B:    r = 8'h08;
            CH_F:    r = 8'h0C;
            CH_N:    r = 8'h0A;
            CH_R:    r = 8'h0D;
            CH_T:    r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

>>> src/jkx_front.sv
module jkx_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [jkx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jkx_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           accept,
    input  logic [7:0]                     in_byte,
    input  logic                           message_end,
    output jkx_pkg::jkx_cmd_t              cmd,
    output logic                           cmd_push
);
    import jkx_pkg::*;

    logic [CFG_W-1:0] key_first_reg;
    logic [CFG_W-1:0] key_second_reg;
    logic [LEN_W-1:0] key_length_reg;

    logic [7:0]       recent_reg [KEY_MAX];
    logic [7:0]       recent_next [KEY_MAX];
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    jkx_phase_t       phase_reg;
    jkx_phase_t       phase_next;
    logic             vhb_reg;
    logic             vhb_next;

    logic [KEY_BITS-1:0] key_all;
    logic [LEN_W-1:0]    len_eff;
    logic [7:0]          win [KEY_MAX];
    logic [LEN_W-1:0]    fill_shift;
    logic                match;

    assign key_all = {key_second_reg, key_first_reg};

    always_comb
    begin
        if (key_length_reg == '0)
            len_eff = LEN_W'(1);
        else if (key_length_reg > LEN_W'(KEY_MAX))
            len_eff = LEN_W'(KEY_MAX);
        else
            len_eff = key_length_reg;
    end

    // shifted window and key compare
    always_comb
    begin
        logic [KIDX_W-1:0] kidx;
        kidx = '0;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            win[i] = (i == 0) ? in_byte : recent_reg[(i == 0) ? 0 : i - 1];
        end
        fill_shift = (fill_reg < LEN_W'(KEY_MAX)) ? fill_reg + LEN_W'(1) : fill_reg;
        match = (fill_shift >= len_eff);
        for (int i = 0; i < KEY_MAX; i++)
        begin
            kidx = KIDX_W'(len_eff - LEN_W'(1) - LEN_W'(i));
            if ((LEN_W'(i) < len_eff) && (win[i] != key_all[{kidx, 3'b000} +: 8]))
                match = 1'b0;
        end
    end

    // phase update and result classification
    always_comb
    begin
        phase_next = phase_reg;
        vhb_next   = vhb_reg;
        cmd        = '{data: 8'h00, kind: KIND_BYTE, emit: 1'b0, tail_fail: 1'b0};
        case (phase_reg)
            PH_SEARCH:
            begin
                if (match)
                    phase_next = PH_COLON;
            end
            PH_COLON:
            begin
                if (in_byte == CH_COLON)
                    phase_next = PH_SPACE;
            end
            PH_SPACE:
            begin
                if (in_byte == CH_QUOTE)
                    phase_next = PH_VALUE;
                else if (!(in_byte == CH_SPACE || in_byte == CH_CR ||
                           in_byte == CH_LF || in_byte == CH_TAB))
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_FAIL;
                    phase_next = PH_DONE;
                end
            end
            PH_VALUE:
            begin
                if (in_byte == CH_BSLASH)
                    phase_next = PH_ESCAPE;
                else if (in_byte == CH_QUOTE)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = vhb_reg ? KIND_DONE : KIND_FAIL;
                    phase_next = PH_DONE;
                end
                else
                begin
                    cmd.emit = 1'b1;
                    cmd.data = in_byte;
                    vhb_next = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                cmd.emit   = 1'b1;
                cmd.data   = unescape(in_byte);
                vhb_next   = 1'b1;
                phase_next = PH_VALUE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        fill_next = fill_reg;
        for (int i = 0; i < KEY_MAX; i++)
            recent_next[i] = recent_reg[i];
        if (phase_reg == PH_SEARCH)
        begin
            fill_next = fill_shift;
            for (int i = 0; i < KEY_MAX; i++)
                recent_next[i] = win[i];
        end

        // last byte rearms the search
        if (message_end)
        begin
            cmd.tail_fail = (phase_next != PH_DONE);
            phase_next    = PH_SEARCH;
            vhb_next      = 1'b0;
            fill_next     = '0;
            for (int i = 0; i < KEY_MAX; i++)
                recent_next[i] = 8'h00;
        end
    end

    assign cmd_push = accept && (cmd.emit || cmd.tail_fail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_first_reg  <= '0;
            key_second_reg <= '0;
            key_length_reg <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY_FIRST:  key_first_reg  <= cfg_data;
                REG_KEY_SECOND: key_second_reg <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            vhb_reg   <= 1'b0;
            fill_reg  <= '0;
            for (int i = 0; i < KEY_MAX; i++)
                recent_reg[i] <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            vhb_reg   <= vhb_next;
            fill_reg  <= fill_next;
            for (int i = 0; i < KEY_MAX; i++)
                recent_reg[i] <= recent_next[i];
        end
    end

endmodule

>>> src/jkx_queue.sv
module jkx_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jkx_pkg::jkx_cmd_t push_cmd,
    input  logic              pop,
    output jkx_pkg::jkx_cmd_t head_cmd,
    output logic              empty,
    output logic              full
);
    import jkx_pkg::*;

    jkx_cmd_t        slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + Q_CW'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

>>> src/jkx_back.sv
module jkx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  jkx_pkg::jkx_cmd_t head_cmd,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic [1:0]        kind
);
    import jkx_pkg::*;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    jkx_kind_t  kind_reg;
    logic       second_reg;
    logic       load;
    logic       take_first;

    // queue not empty and output register free or emptying this cycle
    assign load       = !empty && (!out_valid_reg || out_ready);
    assign take_first = head_cmd.emit && !second_reg;
    assign pop        = load && !(take_first && head_cmd.tail_fail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            second_reg    <= take_first && head_cmd.tail_fail;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (take_first)
            begin
                out_byte_reg <= head_cmd.data;
                kind_reg     <= head_cmd.kind;
            end
            else
            begin
                out_byte_reg <= 8'h00;
                kind_reg     <= KIND_FAIL;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;

endmodule

>>> src/json_key_string_value_extractor_top.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+----------------------------------
// input    | in        | in_valid / in_ready  | in_byte, message_end
// output   | out       | out_valid / out_ready| out_byte, kind
// config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one input beat per cycle; the front end classifies each byte in the cycle it is taken
// a byte ending a message mid-value can give two output beats, which the back end
// sends one after the other from one queue entry
// an input beat reaches the output through the queue write and then the output register
// in_ready drops only while the four-entry queue is full; cfg_ready is always high
// reset clears key words, search window and all valid state; key length resets to one
module json_key_string_value_extractor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          message_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic [1:0]                    kind,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jkx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jkx_pkg::CFG_W-1:0]     cfg_data
);
    import jkx_pkg::*;

    jkx_cmd_t front_cmd;
    jkx_cmd_t head_cmd;
    logic     cmd_push;
    logic     q_pop;
    logic     q_empty;
    logic     q_full;
    logic     accept;

    // key registers take every write beat straight away
    assign cfg_ready = 1'b1;

    // room for one more entry is all the front end needs
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // window compare and phase tracking
    jkx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .in_byte     (in_byte),
        .message_end (message_end),
        .cmd         (front_cmd),
        .cmd_push    (cmd_push)
    );

    // decouples byte intake from output stalls
    jkx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // turns queue entries into output beats
    jkx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind)
    );

endmodule
